// ----- rtl/core/txc_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console package
// Geometry, key codes, op codes and the cursor type of the console writer.
// ----------------------------------------------------------------------------
package txc_pkg;

  localparam int unsigned COLS         = 80;
  localparam int unsigned ROWS         = 30;
  localparam int unsigned BUFFER_ROWS  = 60;
  localparam int unsigned GLYPH_WIDTH  = 8;
  localparam int unsigned GLYPH_HEIGHT = 16;

  localparam int unsigned BUF_CELLS = COLS * BUFFER_ROWS;

  // The cell, x/y and scroll widths are fixed by the port fields.
  localparam int unsigned CELL_W = 13;
  localparam int unsigned XY_W   = 10;
  localparam int unsigned SC_W   = 5;
  localparam int unsigned BYTE_W = 8;

  // Row counter holds BUFFER_ROWS itself before the buffer wrap.
  localparam int unsigned ROW_W = $clog2(BUFFER_ROWS + 1);
  localparam int unsigned COL_W = $clog2(COLS);

  localparam int unsigned TAB_SPACES = 4;
  localparam int unsigned TAB_W      = $clog2(TAB_SPACES);

  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_LOCK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [BYTE_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] KEY_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] KEY_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] SPACE_BYTE    = 8'd32;

  typedef struct packed {
    logic [CELL_W-1:0] idx;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cursor_t;

  typedef struct packed {
    logic [BYTE_W-1:0] chr;
    logic [BYTE_W-1:0] clr;
  } cell_t;

endpackage

// ----- rtl/core/text_console_cell_writer.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer
// Text-mode console engine: character/color cell store, write cursor, locked
// front position, scrolling window and cell readback.
// ----------------------------------------------------------------------------
//
//   channel | direction | signals
//   --------+-----------+--------------------------------------------------
//   in      | sink      | in_valid_i, in_ready_o, op/ch/color/cell_address
//   out     | source    | out_valid_o, out_ready_i, cursor and readback
//   cfg     | sink      | cfg_valid_i, cfg_ready_o, cfg_fill_color_i
//
// After reset a clearing pass writes zero to all BUF_CELLS cells, one cell a
// cycle, and no input beat is taken meanwhile. A printed character, newline
// or backspace passes a store step, a read the read register, a tab one store
// step per space, then the result state; lock, unused ops and reads past the
// buffer end go straight to it. A scroll clears the COLS cells of the new line
// one at a time through the single cell store port. One item is worked at a
// time; the result register lets the next beat be accepted while one waits.
// ----------------------------------------------------------------------------
module text_console_cell_writer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [txc_pkg::BYTE_W-1:0]   ch_i,
  input  logic [txc_pkg::BYTE_W-1:0]   color_i,
  input  logic [txc_pkg::CELL_W-1:0]   cell_address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [txc_pkg::XY_W-1:0]     pixel_x_o,
  output logic [txc_pkg::XY_W-1:0]     pixel_y_o,
  output logic [txc_pkg::CELL_W-1:0]   cursor_cell_o,
  output logic [txc_pkg::SC_W-1:0]     scroll_lines_o,
  output logic [txc_pkg::BYTE_W-1:0]   read_char_o,
  output logic [txc_pkg::BYTE_W-1:0]   read_color_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [txc_pkg::BYTE_W-1:0]   cfg_fill_color_i
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  localparam logic [txc_pkg::CELL_W-1:0] LAST_CELL =
    txc_pkg::CELL_W'(txc_pkg::BUF_CELLS - 1);
  localparam logic [txc_pkg::CELL_W-1:0] BUF_END = txc_pkg::CELL_W'(txc_pkg::BUF_CELLS);
  localparam logic [txc_pkg::COL_W-1:0]  LAST_COL = txc_pkg::COL_W'(txc_pkg::COLS - 1);

  logic [2:0]                    state_q, state_d;
  txc_pkg::cursor_t              cur_q, cur_d;
  logic [txc_pkg::CELL_W-1:0]    front_q, front_d;
  logic [txc_pkg::SC_W-1:0]      sc_q, sc_d;
  logic [txc_pkg::BYTE_W-1:0]    fill_q;
  logic [txc_pkg::BYTE_W-1:0]    ch_q, ch_d;
  logic [txc_pkg::BYTE_W-1:0]    color_q, color_d;
  logic [txc_pkg::TAB_W-1:0]     tab_left_q, tab_left_d;
  logic [txc_pkg::CELL_W-1:0]    clr_q, clr_d;
  logic [txc_pkg::COL_W-1:0]     clr_cnt_q, clr_cnt_d;
  txc_pkg::cell_t                rdat_q, rdat_d;
  logic                          out_valid_q, out_valid_d;
  logic [txc_pkg::XY_W-1:0]      x_q, x_d, y_q, y_d;
  logic [txc_pkg::CELL_W-1:0]    cell_out_q, cell_out_d;
  logic [txc_pkg::SC_W-1:0]      sc_out_q, sc_out_d;
  txc_pkg::cell_t                rd_out_q, rd_out_d;

  txc_pkg::cell_t                mem [txc_pkg::BUF_CELLS];
  txc_pkg::cell_t                mem_rdata_q;
  logic                          mem_we, mem_re;
  logic [txc_pkg::CELL_W-1:0]    mem_waddr;
  txc_pkg::cell_t                mem_wdata;

  logic                          in_fire;
  logic                          is_nl, is_tab, is_bs, bs_ok, scroll_hit, more_tab;
  txc_pkg::cursor_t              adv, adv_wrap, cur_wrap;
  logic [txc_pkg::ROW_W-1:0]     win_row;
  logic [txc_pkg::CELL_W-1:0]    clr_inc;
  logic [txc_pkg::SC_W-1:0]      sc_inc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign is_nl    = (ch_q == txc_pkg::KEY_NEWLINE);
  assign is_tab   = (ch_q == txc_pkg::KEY_TAB);
  assign is_bs    = (ch_q == txc_pkg::KEY_BACKSPACE);
  assign bs_ok    = (front_q < cur_q.idx);
  assign more_tab = is_tab && (tab_left_q != '0);

  // Cursor after a printed cell or a newline, before the buffer-end wrap.
  always_comb begin
    adv = cur_q;
    if (is_nl) begin
      adv.col = '0;
      adv.row = cur_q.row + 1'b1;
      adv.idx = cur_q.idx - txc_pkg::CELL_W'(cur_q.col) + txc_pkg::CELL_W'(txc_pkg::COLS);
    end else begin
      adv.idx = cur_q.idx + 1'b1;
      if (cur_q.col == LAST_COL) begin
        adv.col = '0;
        adv.row = cur_q.row + 1'b1;
      end else begin
        adv.col = cur_q.col + 1'b1;
      end
    end
  end

  // The window ends at a row boundary, so comparing rows replaces the
  // multiply of (ROWS + scroll) by COLS.
  assign win_row    = txc_pkg::ROW_W'(txc_pkg::ROWS) + txc_pkg::ROW_W'(sc_q);
  assign scroll_hit = (adv.col == '0) && (adv.row == win_row);
  assign sc_inc     = (sc_q == txc_pkg::SC_W'(txc_pkg::ROWS - 1)) ? '0 : sc_q + 1'b1;
  assign clr_inc    = (clr_q == LAST_CELL) ? '0 : clr_q + 1'b1;

  always_comb begin
    adv_wrap = adv;
    if (adv.idx >= BUF_END) begin
      adv_wrap = '0;
    end
    cur_wrap = cur_q;
    if (cur_q.idx >= BUF_END) begin
      cur_wrap = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    front_d     = front_q;
    sc_d        = sc_q;
    ch_d        = ch_q;
    color_d     = color_q;
    tab_left_d  = tab_left_q;
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    rdat_d      = rdat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    x_d         = x_q;
    y_d         = y_q;
    cell_out_d  = cell_out_q;
    sc_out_d    = sc_out_q;
    rd_out_d    = rd_out_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q.idx;
    mem_wdata   = '0;
    mem_re      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_inc;
        if (clr_q == LAST_CELL) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          ch_d       = ch_i;
          color_d    = color_i;
          tab_left_d = txc_pkg::TAB_W'(txc_pkg::TAB_SPACES - 1);
          rdat_d     = '0;
          case (op_i)
            txc_pkg::OP_PUT: begin
              state_d = S_STEP;
            end
            txc_pkg::OP_LOCK: begin
              front_d = cur_q.idx;
              state_d = S_RESP;
            end
            txc_pkg::OP_READ: begin
              if (cell_address_i < BUF_END) begin
                mem_re  = 1'b1;
                state_d = S_READ;
              end else begin
                state_d = S_RESP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_STEP: begin
        if (is_bs) begin
          if (bs_ok) begin
            mem_we    = 1'b1;
            mem_waddr = cur_q.idx - 1'b1;
            cur_d.idx = cur_q.idx - 1'b1;
            if (cur_q.col == '0) begin
              cur_d.col = LAST_COL;
              cur_d.row = cur_q.row - 1'b1;
            end else begin
              cur_d.col = cur_q.col - 1'b1;
            end
          end
          state_d = S_RESP;
        end else begin
          if (!is_nl) begin
            mem_we          = 1'b1;
            mem_wdata.chr   = is_tab ? txc_pkg::SPACE_BYTE : ch_q;
            mem_wdata.clr   = is_tab ? fill_q : color_q;
          end
          if (scroll_hit) begin
            // The cursor stays unwrapped until the new line is cleared.
            cur_d     = adv;
            sc_d      = sc_inc;
            clr_d     = (adv.idx >= BUF_END) ? adv.idx - BUF_END : adv.idx;
            clr_cnt_d = '0;
            state_d   = S_SCROLL;
          end else begin
            cur_d = adv_wrap;
            if (more_tab) begin
              tab_left_d = tab_left_q - 1'b1;
            end else begin
              state_d = S_RESP;
            end
          end
        end
      end
      S_SCROLL: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_q;
        mem_wdata.chr = txc_pkg::SPACE_BYTE;
        mem_wdata.clr = fill_q;
        clr_d         = clr_inc;
        clr_cnt_d     = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_COL) begin
          cur_d = cur_wrap;
          if (more_tab) begin
            tab_left_d = tab_left_q - 1'b1;
            state_d    = S_STEP;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_READ: begin
        rdat_d  = mem_rdata_q;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          x_d = (cur_q.col == LAST_COL) ? txc_pkg::XY_W'(1) :
                txc_pkg::XY_W'(txc_pkg::GLYPH_WIDTH) * txc_pkg::XY_W'(cur_q.col) + 1'b1;
          y_d = txc_pkg::XY_W'(txc_pkg::GLYPH_HEIGHT) * txc_pkg::XY_W'(cur_q.row) + 1'b1;
          cell_out_d = cur_q.idx;
          sc_out_d   = sc_q;
          rd_out_d   = rdat_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cur_q       <= '0;
      front_q     <= '0;
      sc_q        <= '0;
      fill_q      <= 8'hFF;
      tab_left_q  <= '0;
      clr_q       <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      front_q     <= front_d;
      sc_q        <= sc_d;
      tab_left_q  <= tab_left_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fill_q <= cfg_fill_color_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    color_q    <= color_d;
    rdat_q     <= rdat_d;
    x_q        <= x_d;
    y_q        <= y_d;
    cell_out_q <= cell_out_d;
    sc_out_q   <= sc_out_d;
    rd_out_q   <= rd_out_d;
  end

  // Single cell store port: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[cell_address_i];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = x_q;
  assign pixel_y_o      = y_q;
  assign cursor_cell_o  = cell_out_q;
  assign scroll_lines_o = sc_out_q;
  assign read_char_o    = rd_out_q.chr;
  assign read_color_o   = rd_out_q.clr;

`ifndef SYNTH
  // Linear cell, row and column describe the same cursor between items.
  a_cursor_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      (cur_q.idx == txc_pkg::CELL_W'(cur_q.row) * txc_pkg::CELL_W'(txc_pkg::COLS)
                    + txc_pkg::CELL_W'(cur_q.col)))
    else $error("cursor cell does not match row and column");

  a_cursor_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_cell_o < BUF_END) && (scroll_lines_o < txc_pkg::ROWS))
    else $error("reported cursor or scroll count out of range");

  a_lock_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == txc_pkg::OP_LOCK)) |=> (front_q == cur_q.idx))
    else $error("front lock did not capture the cursor");

  a_scroll_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && !is_bs && scroll_hit) |=>
      (state_q == S_SCROLL && sc_q != $past(sc_q)))
    else $error("window end reached without a scroll");
`endif

endmodule

// ----- dv/console_cell_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console cell checker
// Monitors the input, result and fill color channels of the console writer.
// It keeps its own copy of the cell stores, cursors and scroll count, works
// out the result of every accepted input beat and compares each result beat
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module console_cell_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 op_i,
  input  logic [txc_pkg::BYTE_W-1:0] ch_i,
  input  logic [txc_pkg::BYTE_W-1:0] color_i,
  input  logic [txc_pkg::CELL_W-1:0] cell_address_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [txc_pkg::XY_W-1:0]   pixel_x_i,
  input  logic [txc_pkg::XY_W-1:0]   pixel_y_i,
  input  logic [txc_pkg::CELL_W-1:0] cursor_cell_i,
  input  logic [txc_pkg::SC_W-1:0]   scroll_lines_i,
  input  logic [txc_pkg::BYTE_W-1:0] read_char_i,
  input  logic [txc_pkg::BYTE_W-1:0] read_color_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [txc_pkg::BYTE_W-1:0] cfg_fill_color_i,
  output int                         outstanding_o,
  output int                         fail_count_o
);

  import txc_pkg::*;

  typedef struct packed {
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [CELL_W-1:0] pos;
    logic [SC_W-1:0]   scroll;
    logic [BYTE_W-1:0] chr;
    logic [BYTE_W-1:0] clr;
  } console_view_t;

  logic [BYTE_W-1:0] glyph_mem [BUF_CELLS];
  logic [BYTE_W-1:0] tint_mem  [BUF_CELLS];
  int unsigned       cursor_q;
  int unsigned       front_q;
  int unsigned       scroll_q;
  logic [BYTE_W-1:0] fill_q;
  console_view_t     pending_views [$];
  int                mismatches = 0;

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // The new line is cleared from the cursor on, after the scroll count moves.
  function automatic void clear_line();
    int unsigned a;
    int unsigned i;
    scroll_q = (scroll_q + 1 >= ROWS) ? 0 : scroll_q + 1;
    for (i = 0; i < COLS; i++) begin
      a = (cursor_q + i) % BUF_CELLS;
      glyph_mem[a] = SPACE_BYTE;
      tint_mem[a]  = fill_q;
    end
  endfunction

  function automatic void wrap_cursor();
    if (cursor_q == (ROWS + scroll_q) * COLS) clear_line();
    if (cursor_q >= BUF_CELLS) cursor_q = 0;
  endfunction

  function automatic void print_byte(input logic [BYTE_W-1:0] c,
                                     input logic [BYTE_W-1:0] t);
    int unsigned a;
    a = cursor_q % BUF_CELLS;
    glyph_mem[a] = c;
    tint_mem[a]  = t;
    cursor_q     = a + 1;
    wrap_cursor();
  endfunction

  function automatic console_view_t console_step(input logic [1:0]        op,
                                                 input logic [BYTE_W-1:0] ch,
                                                 input logic [BYTE_W-1:0] color,
                                                 input logic [CELL_W-1:0] addr);
    console_view_t v;
    int unsigned   col;
    int unsigned   i;
    v = '0;
    case (op)
      OP_PUT: begin
        if (ch == KEY_NEWLINE) begin
          cursor_q = (cursor_q / COLS) * COLS + COLS;
          wrap_cursor();
        end else if (ch == KEY_TAB) begin
          for (i = 0; i < TAB_SPACES; i++) print_byte(SPACE_BYTE, fill_q);
        end else if (ch == KEY_BACKSPACE) begin
          // Nothing before the locked front may be erased.
          if (front_q < cursor_q) begin
            cursor_q--;
            glyph_mem[cursor_q % BUF_CELLS] = '0;
            tint_mem[cursor_q % BUF_CELLS]  = '0;
          end
        end else begin
          print_byte(ch, color);
        end
      end
      OP_LOCK: front_q = cursor_q;
      OP_READ: begin
        if (addr < BUF_CELLS) begin
          v.chr = glyph_mem[addr];
          v.clr = tint_mem[addr];
        end
      end
      default: ;
    endcase
    col      = cursor_q % COLS;
    v.x      = (col != COLS - 1) ? XY_W'(GLYPH_WIDTH * col + 1) : XY_W'(1);
    v.y      = XY_W'(GLYPH_HEIGHT * (cursor_q / COLS) + 1);
    v.pos    = CELL_W'(cursor_q);
    v.scroll = SC_W'(scroll_q);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    console_view_t want;
    int unsigned   k;
    if (!rst_ni) begin
      for (k = 0; k < BUF_CELLS; k++) begin
        glyph_mem[k] = '0;
        tint_mem[k]  = '0;
      end
      cursor_q = 0;
      front_q  = 0;
      scroll_q = 0;
      fill_q   = 8'hFF;
      pending_views.delete();
    end else begin
      // Results are taken first so that a beat accepted at this edge can
      // never be matched by a result that left the block at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (pending_views.size() == 0) begin
          note_mismatch("result beat with nothing outstanding, cursor_cell",
                        cursor_cell_i, -1);
        end else begin
          want = pending_views.pop_front();
          if (pixel_x_i !== want.x) note_mismatch("pixel_x", pixel_x_i, want.x);
          if (pixel_y_i !== want.y) note_mismatch("pixel_y", pixel_y_i, want.y);
          if (cursor_cell_i !== want.pos) begin
            note_mismatch("cursor_cell", cursor_cell_i, want.pos);
          end
          if (scroll_lines_i !== want.scroll) begin
            note_mismatch("scroll_lines", scroll_lines_i, want.scroll);
          end
          if (read_char_i !== want.chr) note_mismatch("read_char", read_char_i, want.chr);
          if (read_color_i !== want.clr) begin
            note_mismatch("read_color", read_color_i, want.clr);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) fill_q = cfg_fill_color_i;
      if (in_valid_i && in_ready_i) begin
        pending_views.push_back(console_step(op_i, ch_i, color_i, cell_address_i));
      end
    end
    outstanding_o = pending_views.size();
    fail_count_o  = mismatches;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console cell writer testbench
// Drives put, lock, read and unused beats into the console writer with random
// gaps and result stalls, changes the fill color between phases, and gives
// the verdict from the failure count of the console cell checker.
// ----------------------------------------------------------------------------
module testbench;

  import txc_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_ITEMS  = 340;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned ADDR_MAX     = (1 << CELL_W) - 1;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i           = OP_PUT;
  logic [BYTE_W-1:0] ch_i           = '0;
  logic [BYTE_W-1:0] color_i        = '0;
  logic [CELL_W-1:0] cell_address_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [XY_W-1:0]   pixel_x_o;
  logic [XY_W-1:0]   pixel_y_o;
  logic [CELL_W-1:0] cursor_cell_o;
  logic [SC_W-1:0]   scroll_lines_o;
  logic [BYTE_W-1:0] read_char_o;
  logic [BYTE_W-1:0] read_color_o;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [BYTE_W-1:0] cfg_fill_color_i = '0;

  int          outstanding;
  int          fail_count;
  bit          calm        = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold  = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  text_console_cell_writer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .ch_i             (ch_i),
    .color_i          (color_i),
    .cell_address_i   (cell_address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_x_o        (pixel_x_o),
    .pixel_y_o        (pixel_y_o),
    .cursor_cell_o    (cursor_cell_o),
    .scroll_lines_o   (scroll_lines_o),
    .read_char_o      (read_char_o),
    .read_color_o     (read_color_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_fill_color_i (cfg_fill_color_i)
  );

  console_cell_checker u_console_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .op_i             (op_i),
    .ch_i             (ch_i),
    .color_i          (color_i),
    .cell_address_i   (cell_address_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_x_i        (pixel_x_o),
    .pixel_y_i        (pixel_y_o),
    .cursor_cell_i    (cursor_cell_o),
    .scroll_lines_i   (scroll_lines_o),
    .read_char_i      (read_char_o),
    .read_color_i     (read_color_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_fill_color_i (cfg_fill_color_i),
    .outstanding_o    (outstanding),
    .fail_count_o     (fail_count)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Outside the calm phase the result side takes one beat, then stalls for a random stretch.
  always @(negedge clk_i) begin
    if (calm) begin
      out_ready_i = 1'b1;
    end else if (ready_hold != 0) begin
      out_ready_i = 1'b0;
      ready_hold--;
    end else begin
      out_ready_i = 1'b1;
      ready_hold  = pick_gap();
    end
  end

  task automatic send_beat(input logic [1:0]        op,
                           input logic [BYTE_W-1:0] ch,
                           input logic [BYTE_W-1:0] color,
                           input logic [CELL_W-1:0] addr);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    op_i           = op;
    ch_i           = ch;
    color_i        = color;
    cell_address_i = addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_fill(input logic [BYTE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i      = 1'b1;
    cfg_fill_color_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_beat();
    int unsigned       r;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] t;
    logic [CELL_W-1:0] a;
    r = $urandom_range(0, 99);
    c = BYTE_W'($urandom_range(0, 255));
    t = BYTE_W'($urandom_range(0, 255));
    a = CELL_W'($urandom_range(0, ADDR_MAX));
    if (r < 52) begin
      send_beat(OP_PUT, c, t, a);
    end else if (r < 64) begin
      send_beat(OP_PUT, KEY_NEWLINE, t, a);
    end else if (r < 70) begin
      send_beat(OP_PUT, KEY_TAB, t, a);
    end else if (r < 79) begin
      send_beat(OP_PUT, KEY_BACKSPACE, t, a);
    end else if (r < 84) begin
      send_beat(OP_LOCK, c, t, a);
    end else if (r < 97) begin
      // Most reads land inside the buffer; a few go past its end.
      if ($urandom_range(0, 9) == 0) a = CELL_W'($urandom_range(BUF_CELLS, ADDR_MAX));
      else a = CELL_W'($urandom_range(0, BUF_CELLS - 1));
      send_beat(OP_READ, c, t, a);
    end else begin
      send_beat(OP_UNUSED, c, t, a);
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] fill;
    int unsigned       p;
    int unsigned       n;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    write_fill(8'h3C);
    send_beat(OP_READ, 8'h00, 8'h00, 13'd0);
    send_beat(OP_PUT, 8'h00, 8'h00, 13'd0);
    send_beat(OP_PUT, 8'hFF, 8'hFF, 13'd0);
    send_beat(OP_PUT, KEY_TAB, 8'hAA, 13'd0);
    send_beat(OP_READ, 8'h00, 8'h00, 13'd2);
    send_beat(OP_PUT, KEY_BACKSPACE, 8'h00, 13'd0);
    send_beat(OP_READ, 8'h00, 8'h00, 13'd5);
    send_beat(OP_LOCK, 8'h00, 8'h00, 13'd0);
    send_beat(OP_PUT, KEY_BACKSPACE, 8'h00, 13'd0);
    send_beat(OP_PUT, KEY_NEWLINE, 8'h00, 13'd0);
    send_beat(OP_PUT, 8'h41, 8'h0F, 13'd0);
    send_beat(OP_PUT, KEY_BACKSPACE, 8'h00, 13'd0);
    // Stepping back across the row start leaves the cursor in the last column.
    send_beat(OP_PUT, KEY_BACKSPACE, 8'h00, 13'd0);
    send_beat(OP_READ, 8'h00, 8'h00, 13'd1);
    send_beat(OP_READ, 8'h00, 8'h00, CELL_W'(BUF_CELLS - 1));
    send_beat(OP_READ, 8'h00, 8'h00, CELL_W'(BUF_CELLS));
    send_beat(OP_READ, 8'hFF, 8'hFF, CELL_W'(ADDR_MAX));
    send_beat(OP_UNUSED, 8'hFF, 8'hFF, CELL_W'(ADDR_MAX));
    send_beat(OP_LOCK, 8'h00, 8'h00, 13'd0);
    send_beat(OP_PUT, KEY_NEWLINE, 8'h00, 13'd0);
    send_beat(OP_PUT, 8'h7E, 8'h81, 13'd0);
    send_beat(OP_READ, 8'h00, 8'h00, 13'd80);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: fill = 8'h00;
        1: fill = 8'hFF;
        default: fill = BYTE_W'($urandom_range(0, 255));
      endcase
      write_fill(fill);
      calm = (p == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 199) == 0) wait_drained();
        random_beat();
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/txc_pkg.sv
rtl/core/text_console_cell_writer.sv
dv/console_cell_checker.sv
dv/testbench.sv
